// ===== rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 message hash engine.
package sha256_pkg;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int ROUNDS = 64;
    localparam int HASH_WORDS = 8;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        final_word;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } digest_item_t;

    typedef struct packed {
        logic        append;
        logic [31:0] data;
        logic [2:0]  count;
        logic        add_length;
        logic        clear;
    } pack_cmd_t;

    typedef struct packed {
        logic [1:0]  bytes_held;
        logic [3:0]  words_held;
        logic [63:0] message_bits;
    } pack_stat_t;

    typedef struct packed {
        logic        push;
        logic [31:0] word;
        logic        block_full;
    } word_push_t;

    localparam logic [31:0] IV [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== rtl/sha256_packer.sv =====
// Byte packer that assembles message bytes into block words and counts the bit length.
module sha256_packer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::pack_cmd_t  cmd,
    output sha256_pkg::pack_stat_t stat,
    output sha256_pkg::word_push_t push
);

    logic [31:0] acc_reg;
    logic [1:0]  held_reg;
    logic [3:0]  words_reg;
    logic [63:0] bits_reg;

    logic [31:0] mask;
    logic [63:0] merged;
    logic [2:0]  total;
    logic        word_done;

    always_comb
    begin
        mask      = ~(32'hffff_ffff >> {cmd.count, 3'b000});
        merged    = {acc_reg, 32'h0} | ({cmd.data & mask, 32'h0} >> {held_reg, 3'b000});
        total     = {1'b0, held_reg} + cmd.count;
        word_done = cmd.append && (total >= 3'd4);
    end

    assign push.push       = word_done;
    assign push.word       = merged[63:32];
    assign push.block_full = word_done &&
                             (words_reg == 4'(sha256_pkg::WORDS_PER_BLOCK - 1));

    assign stat.bytes_held   = held_reg;
    assign stat.words_held   = words_reg;
    assign stat.message_bits = bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            held_reg  <= '0;
            words_reg <= '0;
            bits_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            acc_reg   <= '0;
            held_reg  <= '0;
            words_reg <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            if (cmd.append)
            begin
                if (word_done)
                begin
                    acc_reg   <= merged[31:0];
                    held_reg  <= 2'(total - 3'd4);
                    words_reg <= words_reg + 4'd1;
                end
                else
                begin
                    acc_reg  <= merged[63:32];
                    held_reg <= total[1:0];
                end
            end
            if (cmd.add_length)
            begin
                bits_reg <= bits_reg + {58'd0, cmd.count, 3'b000};
            end
        end
    end

endmodule

// ===== rtl/sha256_rounds.sv =====
// Compression round unit with message schedule window, working variables and hash state.
module sha256_rounds (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::word_push_t push,
    input  logic                   reset_hash,
    output logic [7:0][31:0]       hash,
    output logic                   done
);

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_UPDATE
    } core_state_t;

    core_state_t state_reg;
    logic [31:0] win_reg [sha256_pkg::WORDS_PER_BLOCK];
    logic [31:0] work_reg [sha256_pkg::HASH_WORDS];
    logic [31:0] hash_reg [sha256_pkg::HASH_WORDS];
    logic [5:0]  round_reg;
    logic        done_reg;

    logic [31:0] sched_next;
    logic [31:0] k_word;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    always_comb
    begin
        k_word     = sha256_pkg::ROUND_K[round_reg];
        sched_next = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9] +
                     small_sigma1(win_reg[14]);
        t1 = work_reg[7] + big_sigma1(work_reg[4]) +
             ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6])) +
             k_word + win_reg[0];
        t2 = big_sigma0(work_reg[0]) +
             ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2]) ^
              (work_reg[1] & work_reg[2]));
    end

    always_comb
    begin
        for (int i = 0; i < sha256_pkg::HASH_WORDS; i++)
        begin
            hash[i] = hash_reg[i];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (push.push || (state_reg == CS_ROUND))
        begin
            for (int i = 0; i < sha256_pkg::WORDS_PER_BLOCK - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[sha256_pkg::WORDS_PER_BLOCK - 1] <= push.push ? push.word : sched_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < sha256_pkg::HASH_WORDS; i++)
            begin
                hash_reg[i] <= sha256_pkg::IV[i];
                work_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                CS_IDLE:
                begin
                    if (push.block_full)
                    begin
                        for (int i = 0; i < sha256_pkg::HASH_WORDS; i++)
                        begin
                            work_reg[i] <= hash_reg[i];
                        end
                        round_reg <= '0;
                        state_reg <= CS_ROUND;
                    end
                    else if (reset_hash)
                    begin
                        for (int i = 0; i < sha256_pkg::HASH_WORDS; i++)
                        begin
                            hash_reg[i] <= sha256_pkg::IV[i];
                        end
                    end
                end
                CS_ROUND:
                begin
                    work_reg[7] <= work_reg[6];
                    work_reg[6] <= work_reg[5];
                    work_reg[5] <= work_reg[4];
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[3] <= work_reg[2];
                    work_reg[2] <= work_reg[1];
                    work_reg[1] <= work_reg[0];
                    work_reg[0] <= t1 + t2;
                    round_reg   <= round_reg + 6'd1;
                    if (round_reg == 6'(sha256_pkg::ROUNDS - 1))
                    begin
                        state_reg <= CS_UPDATE;
                    end
                end
                CS_UPDATE:
                begin
                    for (int i = 0; i < sha256_pkg::HASH_WORDS; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + work_reg[i];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= CS_IDLE;
                end
                default:
                begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sha256_message_hash.sv =====
// Top level of the SHA-256 message hash engine: input sequencer, padding and digest output.
// A message word is taken while the block buffer is filling.
// Each full 64-byte block then holds off input while the shared round unit runs 64
// rounds, one round per cycle, then updates the hash and hands control back.
// A final word adds padding, which fills one or two final blocks, and eight digest words.
// Reset loads the initial hash constants and empties the buffer and bit counter.
module sha256_message_hash (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha256_pkg::msg_item_t    msg,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    output sha256_pkg::digest_item_t digest,
    output logic                     digest_valid,
    input  logic                     digest_stall
);

    localparam logic [31:0] PAD_MARK = 32'h8000_0000;
    localparam logic [3:0]  LEN_WORD_POS = 4'(sha256_pkg::WORDS_PER_BLOCK - 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_OUT
    } top_state_t;

    top_state_t               state_reg;
    logic                     fin_reg;
    logic                     pad_mark_reg;
    logic                     len_hi_reg;
    logic                     len_done_reg;
    logic                     out_valid_reg;
    sha256_pkg::digest_item_t out_item_reg;

    sha256_pkg::pack_cmd_t    pk_cmd;
    sha256_pkg::pack_stat_t   pk_stat;
    sha256_pkg::word_push_t   pk_push;
    logic                     reset_hash;
    logic [7:0][31:0]         hash;
    logic                     core_done;
    logic [2:0]               in_count;
    logic [2:0]               next_index;

    sha256_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pk_cmd),
        .stat  (pk_stat),
        .push  (pk_push)
    );

    sha256_rounds u_rounds (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (pk_push),
        .reset_hash (reset_hash),
        .hash       (hash),
        .done       (core_done)
    );

    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = out_valid_reg;
    assign digest       = out_item_reg;
    assign in_count     = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
    assign next_index   = out_item_reg.word_index + 3'd1;

    always_comb
    begin
        pk_cmd     = '0;
        reset_hash = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    pk_cmd.append     = 1'b1;
                    pk_cmd.data       = msg.data_word;
                    pk_cmd.count      = in_count;
                    pk_cmd.add_length = 1'b1;
                end
            end
            ST_PAD:
            begin
                pk_cmd.append = 1'b1;
                if (len_hi_reg)
                begin
                    pk_cmd.data  = pk_stat.message_bits[31:0];
                    pk_cmd.count = 3'd4;
                end
                else if (!pad_mark_reg)
                begin
                    pk_cmd.data  = PAD_MARK;
                    pk_cmd.count = 3'd1;
                end
                else if (pk_stat.bytes_held != 2'd0)
                begin
                    pk_cmd.data  = '0;
                    pk_cmd.count = 3'd4 - {1'b0, pk_stat.bytes_held};
                end
                else if (pk_stat.words_held != LEN_WORD_POS)
                begin
                    pk_cmd.data  = '0;
                    pk_cmd.count = 3'd4;
                end
                else
                begin
                    pk_cmd.data  = pk_stat.message_bits[63:32];
                    pk_cmd.count = 3'd4;
                end
            end
            ST_COMPRESS:
            begin
                pk_cmd = '0;
            end
            ST_OUT:
            begin
                if (!digest_stall && out_item_reg.last_of_digest)
                begin
                    pk_cmd.clear = 1'b1;
                    reset_hash   = 1'b1;
                end
            end
            default:
            begin
                pk_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= 1'b0;
            pad_mark_reg  <= 1'b0;
            len_hi_reg    <= 1'b0;
            len_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (msg_valid)
                    begin
                        fin_reg      <= msg.final_word;
                        pad_mark_reg <= 1'b0;
                        len_hi_reg   <= 1'b0;
                        len_done_reg <= 1'b0;
                        if (pk_push.block_full)
                        begin
                            state_reg <= ST_COMPRESS;
                        end
                        else if (msg.final_word)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (len_hi_reg)
                    begin
                        len_done_reg <= 1'b1;
                    end
                    else if (!pad_mark_reg)
                    begin
                        pad_mark_reg <= 1'b1;
                    end
                    else if ((pk_stat.bytes_held == 2'd0) &&
                             (pk_stat.words_held == LEN_WORD_POS))
                    begin
                        len_hi_reg <= 1'b1;
                    end
                    if (pk_push.block_full)
                    begin
                        state_reg <= ST_COMPRESS;
                    end
                end
                ST_COMPRESS:
                begin
                    if (core_done)
                    begin
                        if (!fin_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (len_done_reg)
                        begin
                            out_valid_reg               <= 1'b1;
                            out_item_reg.digest_word    <= hash[0];
                            out_item_reg.word_index     <= 3'd0;
                            out_item_reg.last_of_digest <= 1'b0;
                            state_reg                   <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!digest_stall)
                    begin
                        if (out_item_reg.last_of_digest)
                        begin
                            out_valid_reg <= 1'b0;
                            fin_reg       <= 1'b0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            out_item_reg.digest_word    <= hash[next_index];
                            out_item_reg.word_index     <= next_index;
                            out_item_reg.last_of_digest <=
                                (next_index == 3'(sha256_pkg::HASH_WORDS - 1));
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
